// ----- rtl/bba_pkg.sv -----
// ---------------------------------------------------------------------------
// bba_pkg
// shared constants, node entry type and tree index helpers for the buddy
// block allocator
// ---------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

   localparam int MIN_ORDER = 4;
   localparam int MAX_ORDER = 12;
   localparam int LEVELS    = MAX_ORDER - MIN_ORDER;
   localparam int NODES     = (1 << (LEVELS + 1)) - 1;

   localparam int MASK_W  = LEVELS + 1;              // one bit per block size
   localparam int ADDR_W  = LEVELS + 1;              // node index
   localparam int DEPTH_W = $clog2(LEVELS + 1);      // tree depth 0..LEVELS
   localparam int SH_W    = $clog2(MAX_ORDER + 1);   // shift within an offset
   localparam int SIZE_W  = 16;                      // request size port
   localparam int OFF_W   = 12;                      // offset ports
   localparam int K_W     = $clog2(SIZE_W + 1);      // rounded order of a request

   typedef struct packed {
      logic              used;
      logic [MASK_W-1:0] mask;
   } node_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_NO_SPACE = 2'd1,
      STATUS_BAD_FREE = 2'd2
   } status_type;

   // size bit of a node at the given depth
   function automatic logic [MASK_W-1:0] full_mask(input logic [DEPTH_W-1:0] depth);
      return {{(MASK_W-1){1'b0}}, 1'b1} << (DEPTH_W'(LEVELS) - depth);
   endfunction

   // depth of a node index: position of the top bit of index + 1
   function automatic logic [DEPTH_W-1:0] depth_of(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W:0]    a1;
      logic [DEPTH_W-1:0] d;
      a1 = {1'b0, addr} + {{ADDR_W{1'b0}}, 1'b1};
      d  = '0;
      for (int i = 0; i <= ADDR_W; i++) begin
         if (a1[i]) begin
            d = DEPTH_W'(i);
         end
      end
      return d;
   endfunction

   // smallest k with 2^k >= n, zero for n of zero or one
   function automatic logic [K_W-1:0] ceil_log2(input logic [SIZE_W-1:0] n);
      logic [SIZE_W-1:0] m;
      logic [K_W-1:0]    k;
      m = n - {{(SIZE_W-1){1'b0}}, 1'b1};
      k = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (m[i]) begin
            k = K_W'(i + 1);
         end
      end
      if (n == '0) begin
         k = '0;
      end
      return k;
   endfunction

   function automatic logic [ADDR_W-1:0] left_of(input logic [ADDR_W-1:0] a);
      return {a[ADDR_W-2:0], 1'b1};
   endfunction

   function automatic logic [ADDR_W-1:0] right_of(input logic [ADDR_W-1:0] a);
      return {a[ADDR_W-2:0], 1'b1} + ADDR_W'(1);
   endfunction

   function automatic logic [ADDR_W-1:0] parent_of(input logic [ADDR_W-1:0] a);
      logic [ADDR_W-1:0] t;
      t = a - ADDR_W'(1);
      return {1'b0, t[ADDR_W-1:1]};
   endfunction

   // odd index is a left child
   function automatic logic [ADDR_W-1:0] sibling_of(input logic [ADDR_W-1:0] a);
      return a[0] ? (a + ADDR_W'(1)) : (a - ADDR_W'(1));
   endfunction

   // a used node offers no free space
   function automatic logic [MASK_W-1:0] live_mask(input node_type n);
      return n.used ? '0 : n.mask;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/buddy_block_allocator_core.sv -----
// ---------------------------------------------------------------------------
// buddy_block_allocator_core
// buddy allocator over a 4 KiB pool with 16-byte minimum blocks, tree state
// held in a single node memory
// ---------------------------------------------------------------------------
// usage: after reset the core sweeps the node memory once to set every node
// to its full free size, keeping busy high meanwhile. a command is
// taken on a rising edge with start high and busy low. an allocate walks down
// the tree one level per cycle (one read of both children per level), marks
// the chosen node used and then walks back up one level per cycle, rewriting
// each ancestor from its two children. a free walks down by offset one level
// per cycle and climbs back the same way. a request above 4 KiB answers on
// the next cycle. each result is a single-cycle transfer marked by rsp_strobe;
// the receiver cannot stall it, so it must take the result in that cycle.
// a new command may be given in the very cycle its predecessor's result is
// shown. status: ok, no space (request too big or no fitting block) or bad
// free (no used block starts at the offset); rsp_block_offset is zero unless
// an allocate succeeds.
// ---------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_mode,
   input  wire logic [bba_pkg::SIZE_W-1:0]      req_request_size,
   input  wire logic [bba_pkg::OFF_W-1:0]       req_free_offset,
   output logic                                 rsp_strobe,
   output logic [1:0]                           rsp_status,
   output logic [bba_pkg::OFF_W-1:0]            rsp_block_offset
);

   // one-hot sequencer states
   typedef enum logic [5:0] {
      S_CLEAR = 6'b000001,   // initial sweep of the node memory
      S_IDLE  = 6'b000010,
      S_AROOT = 6'b000100,   // root entry arrives, fetch its children
      S_ADESC = 6'b001000,   // allocate descent, one level per cycle
      S_FDESC = 6'b010000,   // free descent, one level per cycle
      S_UP    = 6'b100000    // ancestor rewrite, one level per cycle
   } state_type;

   // node memory: one write port, two registered read ports
   bba_pkg::node_type node_mem [0:bba_pkg::NODES-1];
   bba_pkg::node_type rd_a_ff;
   bba_pkg::node_type rd_b_ff;
   logic [bba_pkg::ADDR_W-1:0] rd_a_addr;
   logic [bba_pkg::ADDR_W-1:0] rd_b_addr;
   logic                       wr_en;
   logic [bba_pkg::ADDR_W-1:0] wr_addr;
   bba_pkg::node_type          wr_data;

   // sequencer state
   state_type                     state_ff, state_in;
   logic [bba_pkg::ADDR_W-1:0]    clr_ff, clr_in;
   logic [bba_pkg::ADDR_W-1:0]    node_ff, node_in;
   logic [bba_pkg::DEPTH_W-1:0]   depth_ff, depth_in;
   logic [bba_pkg::DEPTH_W-1:0]   tdepth_ff, tdepth_in;
   bba_pkg::node_type             cur_ff, cur_in;
   logic [bba_pkg::OFF_W-1:0]     off_ff, off_in;
   logic [bba_pkg::OFF_W-1:0]     target_ff, target_in;
   logic                          free_op_ff, free_op_in;

   // result register
   logic                          rsp_strobe_ff, rsp_strobe_in;
   bba_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic [bba_pkg::OFF_W-1:0]     rsp_offset_ff, rsp_offset_in;

   // request decode
   logic [bba_pkg::K_W-1:0]       req_k;
   logic [bba_pkg::K_W-1:0]       req_td;

   // descent and rewrite terms
   logic [bba_pkg::MASK_W-1:0]    rq_mask;
   logic [bba_pkg::MASK_W-1:0]    lm, rm;
   logic                          fits_l, fits_r, go_left;
   logic                          at_leaf, child_leaf;
   logic [bba_pkg::MASK_W-1:0]    child_full;
   logic                          node_is_free;
   logic [bba_pkg::ADDR_W-1:0]    child_addr;
   logic [bba_pkg::ADDR_W-1:0]    parent_addr;
   logic [bba_pkg::OFF_W-1:0]     low_bits;
   logic                          aligned;
   logic                          tgt_bit;
   bba_pkg::node_type             up_l, up_r;
   logic                          parent_free;
   bba_pkg::node_type             parent_new;

   // memory ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= node_mem[rd_a_addr];
      rd_b_ff <= node_mem[rd_b_addr];
   end

   // request decode: td is the depth of a block of the rounded size
   always_comb begin
      req_k = bba_pkg::ceil_log2(req_request_size);
      if (req_k < bba_pkg::K_W'(bba_pkg::MIN_ORDER)) begin
         req_td = bba_pkg::K_W'(bba_pkg::LEVELS);
      end else begin
         req_td = bba_pkg::K_W'(bba_pkg::MAX_ORDER) - req_k;
      end
   end

   // allocate descent terms, children on read ports a (left) and b (right)
   always_comb begin
      rq_mask    = bba_pkg::full_mask(tdepth_ff);
      lm         = bba_pkg::live_mask(rd_a_ff);
      rm         = bba_pkg::live_mask(rd_b_ff);
      fits_l     = (lm >= rq_mask);
      fits_r     = (rm >= rq_mask);
      go_left    = !rd_a_ff.used &&
                   (((lm & rq_mask) != '0) ||
                    (fits_l && fits_r && (lm <= rm)) ||
                    (fits_l && !fits_r));
      at_leaf    = (depth_ff == bba_pkg::DEPTH_W'(bba_pkg::LEVELS));
      child_leaf = ((depth_ff + bba_pkg::DEPTH_W'(1)) == bba_pkg::DEPTH_W'(bba_pkg::LEVELS));
      child_full = bba_pkg::full_mask(depth_ff + bba_pkg::DEPTH_W'(1));
      node_is_free = !cur_ff.used &&
                     (at_leaf ||
                      (!rd_a_ff.used && !rd_b_ff.used &&
                       (rd_a_ff.mask == child_full) && (rd_b_ff.mask == child_full)));
   end

   // free descent terms: block start must match the offset's low bits
   always_comb begin
      low_bits = ~({bba_pkg::OFF_W{1'b1}} <<
                   (bba_pkg::SH_W'(bba_pkg::MAX_ORDER) - bba_pkg::SH_W'(depth_ff)));
      aligned  = ((target_ff & low_bits) == '0);
      tgt_bit  = target_ff[bba_pkg::SH_W'(bba_pkg::MAX_ORDER - 1) - bba_pkg::SH_W'(depth_ff)];
   end

   // ancestor rewrite: parent on port a, sibling on port b, child in cur_ff
   always_comb begin
      parent_addr = bba_pkg::parent_of(node_ff);
      if (node_ff[0]) begin
         up_l = cur_ff;
         up_r = rd_b_ff;
      end else begin
         up_l = rd_b_ff;
         up_r = cur_ff;
      end
      parent_free = !rd_a_ff.used && !up_l.used && !up_r.used &&
                    (up_l.mask == bba_pkg::full_mask(depth_ff)) &&
                    (up_r.mask == bba_pkg::full_mask(depth_ff));
      parent_new.used = rd_a_ff.used;
      if (parent_free) begin
         parent_new.mask = bba_pkg::full_mask(depth_ff - bba_pkg::DEPTH_W'(1));
      end else begin
         parent_new.mask = bba_pkg::live_mask(up_l) | bba_pkg::live_mask(up_r);
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      node_in       = node_ff;
      depth_in      = depth_ff;
      tdepth_in     = tdepth_ff;
      cur_in        = cur_ff;
      off_in        = off_ff;
      target_in     = target_ff;
      free_op_in    = free_op_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = cur_ff;
      rd_a_addr     = '0;   // root, fetched on every idle cycle
      rd_b_addr     = '0;
      child_addr    = go_left ? bba_pkg::left_of(node_ff) : bba_pkg::right_of(node_ff);

      case (state_ff)
         S_CLEAR: begin
            wr_en        = 1'b1;
            wr_addr      = clr_ff;
            wr_data.used = 1'b0;
            wr_data.mask = bba_pkg::full_mask(bba_pkg::depth_of(clr_ff));
            clr_in       = clr_ff + bba_pkg::ADDR_W'(1);
            if (clr_ff == bba_pkg::ADDR_W'(bba_pkg::NODES - 1)) begin
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            if (start) begin
               free_op_in = req_mode;
               target_in  = req_free_offset;
               node_in    = '0;
               depth_in   = '0;
               off_in     = '0;
               tdepth_in  = bba_pkg::DEPTH_W'(req_td);
               if (req_mode) begin
                  state_in = S_FDESC;
               end else if (req_k > bba_pkg::K_W'(bba_pkg::MAX_ORDER)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = bba_pkg::STATUS_NO_SPACE;
                  rsp_offset_in = '0;
               end else begin
                  state_in = S_AROOT;
               end
            end
         end

         S_AROOT: begin
            cur_in    = rd_a_ff;
            rd_a_addr = bba_pkg::left_of(node_ff);
            rd_b_addr = bba_pkg::right_of(node_ff);
            state_in  = S_ADESC;
         end

         S_ADESC: begin
            if ((depth_ff > tdepth_ff) || cur_ff.used) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_NO_SPACE;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end else if ((depth_ff == tdepth_ff) && node_is_free) begin
               // claim the node, its mask stays as it was
               wr_en        = 1'b1;
               wr_addr      = node_ff;
               wr_data.used = 1'b1;
               wr_data.mask = cur_ff.mask;
               cur_in       = wr_data;
               if (node_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = bba_pkg::STATUS_OK;
                  rsp_offset_in = off_ff;
                  state_in      = S_IDLE;
               end else begin
                  rd_a_addr = parent_addr;
                  rd_b_addr = bba_pkg::sibling_of(node_ff);
                  state_in  = S_UP;
               end
            end else if (at_leaf || (depth_ff == tdepth_ff)) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_NO_SPACE;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end else begin
               // step to the chosen child and fetch its children unless it is a leaf
               node_in  = child_addr;
               depth_in = depth_ff + bba_pkg::DEPTH_W'(1);
               cur_in   = go_left ? rd_a_ff : rd_b_ff;
               if (!go_left) begin
                  off_in = off_ff | (bba_pkg::OFF_W'(1) <<
                           (bba_pkg::SH_W'(bba_pkg::MAX_ORDER - 1) - bba_pkg::SH_W'(depth_ff)));
               end
               if (!child_leaf) begin
                  rd_a_addr = bba_pkg::left_of(child_addr);
                  rd_b_addr = bba_pkg::right_of(child_addr);
               end
            end
         end

         S_FDESC: begin
            if (aligned && rd_a_ff.used) begin
               // release the block as a whole free node
               wr_en        = 1'b1;
               wr_addr      = node_ff;
               wr_data.used = 1'b0;
               wr_data.mask = bba_pkg::full_mask(depth_ff);
               cur_in       = wr_data;
               if (node_ff == '0) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = bba_pkg::STATUS_OK;
                  rsp_offset_in = '0;
                  state_in      = S_IDLE;
               end else begin
                  rd_a_addr = parent_addr;
                  rd_b_addr = bba_pkg::sibling_of(node_ff);
                  state_in  = S_UP;
               end
            end else if (at_leaf) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_BAD_FREE;
               rsp_offset_in = '0;
               state_in      = S_IDLE;
            end else begin
               node_in   = tgt_bit ? bba_pkg::right_of(node_ff) : bba_pkg::left_of(node_ff);
               depth_in  = depth_ff + bba_pkg::DEPTH_W'(1);
               rd_a_addr = tgt_bit ? bba_pkg::right_of(node_ff) : bba_pkg::left_of(node_ff);
            end
         end

         S_UP: begin
            wr_en    = 1'b1;
            wr_addr  = parent_addr;
            wr_data  = parent_new;
            cur_in   = parent_new;
            node_in  = parent_addr;
            depth_in = depth_ff - bba_pkg::DEPTH_W'(1);
            if (parent_addr == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = bba_pkg::STATUS_OK;
               rsp_offset_in = free_op_ff ? '0 : off_ff;
               state_in      = S_IDLE;
            end else begin
               rd_a_addr = bba_pkg::parent_of(parent_addr);
               rd_b_addr = bba_pkg::sibling_of(parent_addr);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      depth_ff      <= depth_in;
      tdepth_ff     <= tdepth_in;
      cur_ff        <= cur_in;
      off_ff        <= off_in;
      target_ff     <= target_in;
      free_op_ff    <= free_op_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   assign busy             = (state_ff != S_IDLE);
   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_offset_ff;

endmodule

`default_nettype wire

// ----- verif/tb_buddy_block_allocator_core.sv -----
// ---------------------------------------------------------------------------
// tb_buddy_block_allocator_core
// self-checking bench for the buddy block allocator core: a queue-fed driver
// issues allocate and release commands with random idle gaps, a shadow copy
// of the node tree predicts every answer and a monitor checks each transfer
// ---------------------------------------------------------------------------
module tb_buddy_block_allocator_core;
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic {
      CMD_ALLOC = 1'b0,
      CMD_FREE  = 1'b1
   } command_type;

   typedef struct {
      command_type                mode;
      logic [bba_pkg::SIZE_W-1:0] size;
      logic [bba_pkg::OFF_W-1:0]  offset;
      int unsigned                gap;     // idle cycles before the command is offered
      bit                         drain;   // hold off until all answers are back
   } command_item;

   typedef struct packed {
      bba_pkg::status_type       status;
      logic [bba_pkg::OFF_W-1:0] offset;
   } outcome_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   // ports of the core
   logic                       start            = 1'b0;
   logic                       busy;
   logic                       req_mode         = CMD_ALLOC;
   logic [bba_pkg::SIZE_W-1:0] req_request_size = '0;
   logic [bba_pkg::OFF_W-1:0]  req_free_offset  = '0;
   logic                       rsp_strobe;
   logic [1:0]                 rsp_status;
   logic [bba_pkg::OFF_W-1:0]  rsp_block_offset;

   buddy_block_allocator_core uut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_request_size (req_request_size),
      .req_free_offset  (req_free_offset),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset)
   );

   // -------------------------------------------------------------------------
   // shadow node tree: a used flag and a free-size mask per node, where bit i
   // of a mask stands for a free block of 2^(MIN_ORDER+i) bytes below it
   // -------------------------------------------------------------------------
   logic                       tree_used [bba_pkg::NODES];
   logic [bba_pkg::MASK_W-1:0] tree_mask [bba_pkg::NODES];

   function automatic logic [bba_pkg::MASK_W-1:0] size_bit(int order);
      return bba_pkg::MASK_W'(1) << (order - bba_pkg::MIN_ORDER);
   endfunction

   // a used node offers nothing to its parent
   function automatic logic [bba_pkg::MASK_W-1:0] free_space(int v);
      return tree_used[v] ? '0 : tree_mask[v];
   endfunction

   // node untouched: not used, and both children untouched at their full size
   function automatic bit wholly_free(int v, int order);
      int l;
      if (tree_used[v]) return 1'b0;
      if (order <= bba_pkg::MIN_ORDER) return 1'b1;
      l = 2 * v + 1;
      return !tree_used[l] && !tree_used[l + 1] &&
             tree_mask[l] == size_bit(order - 1) &&
             tree_mask[l + 1] == size_bit(order - 1);
   endfunction

   // rebuild every ancestor of v on the way back to the root
   function automatic void refresh_ancestors(int v, int order);
      while (v != 0) begin
         v = (v - 1) / 2;
         order++;
         if (wholly_free(v, order)) begin
            tree_mask[v] = size_bit(order);
         end else begin
            tree_mask[v] = free_space(2 * v + 1) | free_space(2 * v + 2);
         end
      end
   endfunction

   // state straight after reset: nothing used, every node at its own size
   function automatic void clear_tree();
      int order;
      int level_end;
      order     = bba_pkg::MAX_ORDER;
      level_end = 1;
      for (int v = 0; v < bba_pkg::NODES; v++) begin
         if (v == level_end) begin
            order--;
            level_end = 2 * level_end + 1;
         end
         tree_used[v] = 1'b0;
         tree_mask[v] = size_bit(order);
      end
   endfunction

   function automatic outcome_type predict_alloc(logic [bba_pkg::SIZE_W-1:0] bytes);
      outcome_type                res;
      int                         k;
      int                         order;
      int                         v;
      int                         l;
      int unsigned                base;
      logic [bba_pkg::MASK_W-1:0] want;
      logic [bba_pkg::MASK_W-1:0] lm;
      logic [bba_pkg::MASK_W-1:0] rm;
      bit                         go_left;
      res.status = bba_pkg::STATUS_NO_SPACE;
      res.offset = '0;
      // round up to a power of two, zero bytes counts as one minimum block
      k = 0;
      while (k < bba_pkg::SIZE_W && (32'd1 << k) < 32'(bytes)) k++;
      if (k < bba_pkg::MIN_ORDER) k = bba_pkg::MIN_ORDER;
      if (k > bba_pkg::MAX_ORDER) return res;
      want  = size_bit(k);
      order = bba_pkg::MAX_ORDER;
      v     = 0;
      base  = 0;
      while (1'b1) begin
         if (order < k || tree_used[v]) break;
         if (order == k && wholly_free(v, order)) begin
            tree_used[v] = 1'b1;
            refresh_ancestors(v, order);
            res.status = bba_pkg::STATUS_OK;
            res.offset = bba_pkg::OFF_W'(base);
            return res;
         end
         if (order <= bba_pkg::MIN_ORDER) break;
         l  = 2 * v + 1;
         lm = free_space(l);
         rm = free_space(l + 1);
         // exact size on the left wins, then the tighter fit, else the right
         go_left = !tree_used[l] &&
                   ((lm & want) != '0 ||
                    (lm >= want && rm >= want && lm <= rm) ||
                    (lm >= want && rm < want));
         order--;
         if (go_left) begin
            v = l;
         end else begin
            v    = l + 1;
            base += 32'd1 << order;
         end
      end
      return res;
   endfunction

   function automatic outcome_type predict_release(logic [bba_pkg::OFF_W-1:0] target);
      outcome_type res;
      int          order;
      int          v;
      int unsigned base;
      int unsigned half;
      res.status = bba_pkg::STATUS_BAD_FREE;
      res.offset = '0;
      order      = bba_pkg::MAX_ORDER;
      v          = 0;
      base       = 0;
      // walk down by offset until a used node starts exactly there
      while (1'b1) begin
         if (base == target && tree_used[v]) begin
            tree_used[v] = 1'b0;
            tree_mask[v] = size_bit(order);
            refresh_ancestors(v, order);
            res.status = bba_pkg::STATUS_OK;
            return res;
         end
         if (order <= bba_pkg::MIN_ORDER) break;
         order--;
         half = 32'd1 << order;
         if (target < base + half) begin
            v = 2 * v + 1;
         end else begin
            v    = 2 * v + 2;
            base += half;
         end
      end
      return res;
   endfunction

   function automatic outcome_type predict_command(command_item c);
      return (c.mode == CMD_ALLOC) ? predict_alloc(c.size) : predict_release(c.offset);
   endfunction

   // -------------------------------------------------------------------------
   // command list: built up front against the shadow tree so that releases
   // can name blocks that really are live at that point in the sequence
   // -------------------------------------------------------------------------
   command_item pending_cmds [$];
   outcome_type outcomes_due [$];
   int unsigned live_blocks [$];
   int unsigned freed_blocks [$];
   bit          gapless = 1'b0;

   function automatic void add_command(command_type mode, int unsigned bytes,
                                       int unsigned where, bit drain);
      command_item c;
      outcome_type o;
      int          hit;
      c.mode   = mode;
      c.size   = bba_pkg::SIZE_W'(bytes);
      c.offset = bba_pkg::OFF_W'(where);
      c.gap    = gapless ? 0 : $urandom_range(0, 15);
      c.drain  = drain;
      o        = predict_command(c);
      if (o.status == bba_pkg::STATUS_OK) begin
         if (mode == CMD_ALLOC) begin
            live_blocks.push_back(32'(o.offset));
         end else begin
            hit = -1;
            for (int j = 0; j < live_blocks.size(); j++) begin
               if (live_blocks[j] == c.offset) hit = j;
            end
            if (hit >= 0) live_blocks.delete(hit);
            freed_blocks.push_back(32'(c.offset));
            if (freed_blocks.size() > 32) void'(freed_blocks.pop_front());
         end
      end
      pending_cmds.push_back(c);
   endfunction

   // -------------------------------------------------------------------------
   // driver: offers one command at a time, a transfer happens on an edge with
   // start high and busy low; the expected answer is worked out right there
   // -------------------------------------------------------------------------
   command_item cur_cmd;
   bit          cur_loaded    = 1'b0;
   int unsigned idle_left     = 0;
   int unsigned sent_count    = 0;
   int unsigned granted_count = 0;
   int unsigned release_count = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            outcomes_due.push_back(predict_command(cur_cmd));
            if (cur_cmd.mode == CMD_ALLOC) granted_count++;
            else release_count++;
            cur_loaded = 1'b0;
            sent_count++;
         end
         // a command still waiting on busy keeps start and its fields as they are
         if (!(start && busy)) begin
            if (!cur_loaded && pending_cmds.size() != 0) begin
               cur_cmd    = pending_cmds.pop_front();
               cur_loaded = 1'b1;
               idle_left  = cur_cmd.gap;
            end
            if (cur_loaded && idle_left == 0 &&
                (!cur_cmd.drain || outcomes_due.size() == 0)) begin
               start            <= 1'b1;
               req_mode         <= cur_cmd.mode;
               req_request_size <= cur_cmd.size;
               req_free_offset  <= cur_cmd.offset;
            end else begin
               start <= 1'b0;
               if (idle_left != 0) idle_left--;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // monitor: every strobe is a transfer that must match the oldest answer due
   // -------------------------------------------------------------------------
   int unsigned mismatches    = 0;
   int unsigned refused_count = 0;
   int unsigned bad_rel_count = 0;

   task automatic report_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 10) begin
         $display("[%0t] mismatch on %s: expected %0d, got %0d", $realtime, what, want, got);
      end
   endtask

   always @(posedge clock) begin : result_check
      outcome_type want;
      if (!reset && rsp_strobe) begin
         if (outcomes_due.size() == 0) begin
            report_mismatch("unexpected result, status", 0, 32'(rsp_status));
         end else begin
            want = outcomes_due.pop_front();
            if (rsp_status !== want.status) begin
               report_mismatch("status", 32'(want.status), 32'(rsp_status));
            end
            if (rsp_block_offset !== want.offset) begin
               report_mismatch("block offset", 32'(want.offset), 32'(rsp_block_offset));
            end
            if (want.status == bba_pkg::STATUS_NO_SPACE) refused_count++;
            else if (want.status == bba_pkg::STATUS_BAD_FREE) bad_rel_count++;
         end
      end
   end

   // -------------------------------------------------------------------------
   // stimulus and end of run
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int          pick;
      int          ord;
      int unsigned lo;
      int unsigned hi;
      int unsigned spot;
      bit          growing;
      bit          hold;

      clear_tree();

      // directed: whole pool, extremes of size, zero bytes, odd and stale
      // releases, a descent with no fit, and a full pool
      add_command(CMD_ALLOC, 4096, 4095, 1'b0);
      add_command(CMD_ALLOC, 1, 0, 1'b0);
      add_command(CMD_FREE, 16'hffff, 0, 1'b0);
      add_command(CMD_ALLOC, 4097, 0, 1'b0);
      add_command(CMD_ALLOC, 65535, 4095, 1'b0);
      add_command(CMD_ALLOC, 0, 0, 1'b0);
      add_command(CMD_ALLOC, 1, 0, 1'b0);
      add_command(CMD_ALLOC, 17, 0, 1'b0);
      add_command(CMD_ALLOC, 2048, 0, 1'b0);
      add_command(CMD_FREE, 0, 8, 1'b0);
      add_command(CMD_FREE, 0, 4095, 1'b0);
      add_command(CMD_FREE, 0, 16, 1'b0);
      add_command(CMD_FREE, 0, 16, 1'b0);
      add_command(CMD_ALLOC, 2048, 0, 1'b0);
      add_command(CMD_ALLOC, 16, 0, 1'b0);
      while (live_blocks.size() != 0) begin
         add_command(CMD_FREE, 0, live_blocks[0], 1'b0);
      end
      add_command(CMD_ALLOC, 2048, 0, 1'b0);
      add_command(CMD_ALLOC, 2047, 0, 1'b0);
      add_command(CMD_ALLOC, 16, 0, 1'b0);
      add_command(CMD_FREE, 0, 2048, 1'b0);
      add_command(CMD_FREE, 0, 0, 1'b0);

      // random: phases of growth and shrinkage so the tree fills, fragments
      // and empties again, with a little noise mixed in
      growing = 1'b1;
      for (int i = 0; i < 1130; i++) begin
         if (i % 48 == 0) gapless = ($urandom_range(0, 3) == 0);
         if (i % 96 == 0) growing = $urandom_range(0, 2) != 0;
         hold = (i == 200) || ($urandom_range(0, 63) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            case ($urandom_range(0, 4))
               0: add_command(CMD_ALLOC, $urandom_range(4097, 65535), $urandom, hold);
               1: add_command(CMD_FREE, $urandom, $urandom_range(0, 4095), hold);
               2: begin
                  spot = (freed_blocks.size() != 0) ?
                         freed_blocks[$urandom_range(0, freed_blocks.size() - 1)] :
                         $urandom_range(0, 4095);
                  add_command(CMD_FREE, $urandom, spot, hold);
               end
               3: begin
                  // misaligned: never the start of any block
                  spot = (live_blocks.size() != 0) ?
                         live_blocks[$urandom_range(0, live_blocks.size() - 1)] :
                         0;
                  add_command(CMD_FREE, $urandom, spot + $urandom_range(1, 15), hold);
               end
               default: add_command(CMD_FREE, $urandom, $urandom_range(0, 255) * 16, hold);
            endcase
         end else if ((growing ? pick < 75 : pick < 35) || live_blocks.size() == 0) begin
            // mostly small blocks, the odd large one
            pick = $urandom_range(0, 99);
            ord  = (pick < 45) ? 4 : (pick < 65) ? 5 : (pick < 78) ? 6 : (pick < 86) ? 7 :
                   (pick < 91) ? 8 : (pick < 94) ? 9 : (pick < 96) ? 10 : (pick < 98) ? 11 : 12;
            hi   = 32'd1 << ord;
            lo   = (ord == bba_pkg::MIN_ORDER) ? 1 : (32'd1 << (ord - 1)) + 1;
            add_command(CMD_ALLOC, $urandom_range(lo, hi), $urandom, hold);
         end else begin
            spot = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
            add_command(CMD_FREE, $urandom, spot, hold);
         end
      end

      // the run starts again from a clean tree
      clear_tree();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (!(pending_cmds.size() == 0 && !cur_loaded && !start &&
               outcomes_due.size() == 0)) begin
         @(posedge clock);
      end
      // settle time for any stray strobe
      repeat (40) @(posedge clock);

      $display("covered %0d commands: %0d allocates (%0d refused for space)",
               sent_count, granted_count, refused_count);
      $display("and %0d releases (%0d of them with no block at the offset)",
               release_count, bad_rel_count);
      if (mismatches == 0 && outcomes_due.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // watchdog, far above the slowest legal run
   initial begin
      #2000000;
      $display("timeout with %0d results outstanding", outcomes_due.size());
      $display("FAIL");
      $finish;
   end

endmodule
